FILE: design/sffp_pkg.sv
package sffp_pkg;

    // Frame geometry: nine little-endian 16-bit words on the wire.
    localparam int unsigned FRAME_WORDS   = 9;
    localparam int unsigned FRAME_BYTES   = 18;
    localparam int unsigned CHECKED_WORDS = 8;

    // Width of the byte position counter and of a word index.
    localparam int unsigned POS_W  = $clog2(FRAME_BYTES);
    localparam int unsigned WORD_W = $clog2(FRAME_WORDS);

    // Start marker after reset.
    localparam logic [15:0] START_WORD_RESET = 16'hABCD;

    // One decoded frame as delivered on the result channel.
    typedef struct packed {
        logic               frame_ok;
        logic signed [15:0] command_one;
        logic signed [15:0] command_two;
        logic signed [15:0] right_rpm;
        logic signed [15:0] left_rpm;
        logic signed [15:0] battery_voltage;
        logic signed [15:0] board_temperature;
        logic        [15:0] led_flags;
        logic        [31:0] frames_seen;
        logic        [31:0] checksum_errors;
    } result_t;

endpackage

FILE: design/sffp_frame_core.sv
module sffp_frame_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          rx_byte,
    input  logic [15:0]         start_word,
    output logic                last_pending,
    output logic                result_valid,
    output sffp_pkg::result_t   result
);

    localparam logic [sffp_pkg::POS_W-1:0] FIRST_POS = sffp_pkg::POS_W'(2);
    localparam logic [sffp_pkg::POS_W-1:0] LAST_POS  =
        sffp_pkg::POS_W'(sffp_pkg::FRAME_BYTES - 1);

    logic [7:0]                  last_byte_reg;
    logic [sffp_pkg::POS_W-1:0]  pos_reg;
    logic [15:0]                 words_reg [0:sffp_pkg::FRAME_WORDS-1];
    logic [31:0]                 frame_counter_reg;
    logic [31:0]                 error_counter_reg;

    logic [15:0]                 candidate;
    logic                        start_hit;
    logic                        collecting;
    logic                        complete;
    logic [sffp_pkg::WORD_W-1:0] word_index;
    logic [15:0]                 checksum_word;
    logic [15:0]                 xor_sum;
    logic                        frame_ok;
    logic [31:0]                 frames_next;
    logic [31:0]                 errors_next;

    // Start detection on the byte pair and position bookkeeping.
    assign candidate    = {rx_byte, last_byte_reg};
    assign start_hit    = (candidate == start_word);
    assign collecting   = (pos_reg >= FIRST_POS) && !start_hit;
    assign last_pending = collecting && (pos_reg == LAST_POS);
    assign complete     = step && last_pending;
    assign word_index   = pos_reg[sffp_pkg::POS_W-1:1];

    // The checksum word is finished by the high byte arriving now.
    assign checksum_word = {rx_byte, words_reg[sffp_pkg::FRAME_WORDS-1][7:0]};

    // XOR of the start word and the seven data words.
    always_comb
    begin
        xor_sum = words_reg[0];
        for (int i = 1; i < sffp_pkg::CHECKED_WORDS; i++)
        begin
            xor_sum = xor_sum ^ words_reg[i];
        end
    end

    assign frame_ok    = (words_reg[0] == start_word) && (xor_sum == checksum_word);
    assign frames_next = frame_counter_reg + 32'd1;
    assign errors_next = frame_ok ? error_counter_reg : error_counter_reg + 32'd1;

    // Control state: previous byte, position and the running counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_byte_reg     <= 8'd0;
            pos_reg           <= '0;
            frame_counter_reg <= 32'd0;
            error_counter_reg <= 32'd0;
        end
        else if (step)
        begin
            last_byte_reg <= rx_byte;
            if (start_hit)
            begin
                pos_reg <= FIRST_POS;
            end
            else if (complete)
            begin
                pos_reg           <= '0;
                frame_counter_reg <= frames_next;
                error_counter_reg <= errors_next;
            end
            else if (collecting)
            begin
                pos_reg <= pos_reg + sffp_pkg::POS_W'(1);
            end
        end
    end

    // Frame word storage, one byte lane written per request, both on a start hit.
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            if (start_hit)
            begin
                words_reg[0] <= candidate;
            end
            else if (collecting)
            begin
                if (pos_reg[0])
                begin
                    words_reg[word_index][15:8] <= rx_byte;
                end
                else
                begin
                    words_reg[word_index][7:0] <= rx_byte;
                end
            end
        end
    end

    // Decoded result for the frame that completes on this request.
    assign result_valid               = complete;
    assign result.frame_ok            = frame_ok;
    assign result.command_one         = words_reg[1];
    assign result.command_two         = words_reg[2];
    assign result.right_rpm           = words_reg[3];
    assign result.left_rpm            = words_reg[4];
    assign result.battery_voltage     = words_reg[5];
    assign result.board_temperature   = words_reg[6];
    assign result.led_flags           = words_reg[7];
    assign result.frames_seen         = frames_next;
    assign result.checksum_errors     = errors_next;

endmodule

FILE: design/serial_feedback_frame_parser_unit.sv
// Serial feedback frame parser. Each input request carries one received byte,
// and one byte is taken per clock cycle while in_stall is low. A byte is first
// held in an input register, then updates the frame assembler, and the decoded
// frame lands in the result register. The byte pair matching start_word restarts
// collection at any point, a partial frame is dropped silently, and an
// eighteen-byte frame yields one result with frame_ok, the seven data words
// and the wrapping frame and error counters. Back-pressure reaches the input
// only when the last byte of a frame is waiting and the previous result is
// still held by out_stall. The start marker is written through cfg_write_en and
// cfg_write_data and resets to 0xABCD.
module serial_feedback_frame_parser_unit
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write_en,
    input  logic [15:0]        cfg_write_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         rx_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               frame_ok,
    output logic signed [15:0] command_one,
    output logic signed [15:0] command_two,
    output logic signed [15:0] right_rpm,
    output logic signed [15:0] left_rpm,
    output logic signed [15:0] battery_voltage,
    output logic signed [15:0] board_temperature,
    output logic        [15:0] led_flags,
    output logic        [31:0] frames_seen,
    output logic        [31:0] checksum_errors
);

    logic [15:0]        start_word_reg;
    logic               byte_valid_reg;
    logic [7:0]         byte_reg;
    logic               out_valid_reg;
    sffp_pkg::result_t  result_reg;

    logic               may_finish;
    logic               block;
    logic               step;
    logic               in_take;
    logic               core_valid;
    sffp_pkg::result_t  core_result;

    // The held byte may finish a frame only if the result register frees up.
    assign block    = byte_valid_reg && may_finish && out_valid_reg && out_stall;
    assign step     = byte_valid_reg && !block;
    assign in_stall = block;
    assign in_take  = in_valid && !in_stall;

    // Start marker register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_word_reg <= sffp_pkg::START_WORD_RESET;
        end
        else if (cfg_write_en)
        begin
            start_word_reg <= cfg_write_data;
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
        end
        else if (!block)
        begin
            byte_valid_reg <= in_take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            byte_reg <= rx_byte;
        end
    end

    sffp_frame_core u_core
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .rx_byte      (byte_reg),
        .start_word   (start_word_reg),
        .last_pending (may_finish),
        .result_valid (core_valid),
        .result       (core_result)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (core_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (core_valid)
        begin
            result_reg <= core_result;
        end
    end

    assign out_valid         = out_valid_reg;
    assign frame_ok          = result_reg.frame_ok;
    assign command_one       = result_reg.command_one;
    assign command_two       = result_reg.command_two;
    assign right_rpm         = result_reg.right_rpm;
    assign left_rpm          = result_reg.left_rpm;
    assign battery_voltage   = result_reg.battery_voltage;
    assign board_temperature = result_reg.board_temperature;
    assign led_flags         = result_reg.led_flags;
    assign frames_seen       = result_reg.frames_seen;
    assign checksum_errors   = result_reg.checksum_errors;

`ifndef SYNTHESIS
    // Input back-pressure only comes from a held result.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a held result");

    // A new frame result never overwrites one that is still held.
    assert property (@(posedge clk) disable iff (!rst_n)
        core_valid |-> !(out_valid_reg && out_stall))
        else $error("frame result overwrote a held result");

    // A taken result with nothing new behind it clears the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !core_valid) |=> !out_valid)
        else $error("result delivered twice");
`endif

endmodule

FILE: dv/tb_serial_feedback_frame_parser_unit.sv
`timescale 1ns / 1ps

module tb_serial_feedback_frame_parser_unit;

    // Cycles with no accepted request before the run is declared hung.
    localparam int unsigned QUIET_LIMIT   = 2000;
    // Cycles allowed for the input register and assembler to drain.
    localparam int unsigned SETTLE_CYCLES = 6;
    // Longest sender gap before one request.
    localparam int unsigned MAX_GAP       = 30;

    // Tracks the parser state byte by byte and keeps the frames it should emit.
    class frame_decode_tracker;
        logic [15:0] marker;
        logic [7:0]  last_rx;
        int unsigned byte_pos;
        logic [15:0] words [sffp_pkg::FRAME_WORDS];
        logic [31:0] frame_count;
        logic [31:0] error_count;
        sffp_pkg::result_t decoded_frames [$];
        int unsigned mismatches;

        function new();
            marker         = sffp_pkg::START_WORD_RESET;
            last_rx        = '0;
            byte_pos       = 0;
            frame_count    = '0;
            error_count    = '0;
            mismatches     = 0;
            foreach (words[i])
                words[i] = '0;
        endfunction

        function void set_marker(logic [15:0] value);
            marker = value;
        endfunction

        // Applies one accepted byte and queues a decoded frame when one completes.
        function void take_byte(logic [7:0] b);
            logic [15:0] pair;
            logic [15:0] parity;
            sffp_pkg::result_t r;
            int unsigned idx;
            pair = {b, last_rx};
            if (pair == marker)
            begin
                words[0] = pair;
                byte_pos = 2;
            end
            else if (byte_pos >= 2 && byte_pos < sffp_pkg::FRAME_BYTES)
            begin
                idx = byte_pos / 2;
                if (byte_pos % 2)
                    words[idx][15:8] = b;
                else
                    words[idx][7:0] = b;
                byte_pos++;
            end
            if (byte_pos == sffp_pkg::FRAME_BYTES)
            begin
                parity = '0;
                for (int i = 0; i < sffp_pkg::CHECKED_WORDS; i++)
                    parity ^= words[i];
                r.frame_ok = (words[0] == marker) && (words[8] == parity);
                frame_count++;
                if (!r.frame_ok)
                    error_count++;
                r.command_one       = words[1];
                r.command_two       = words[2];
                r.right_rpm         = words[3];
                r.left_rpm          = words[4];
                r.battery_voltage   = words[5];
                r.board_temperature = words[6];
                r.led_flags         = words[7];
                r.frames_seen       = frame_count;
                r.checksum_errors   = error_count;
                decoded_frames.push_back(r);
                byte_pos = 0;
            end
            last_rx = b;
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                mismatches++;
                $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
            end
        endfunction

        // Compares one delivered frame with the oldest pending one.
        function void match_frame(sffp_pkg::result_t got);
            sffp_pkg::result_t want;
            if (decoded_frames.size() == 0)
            begin
                mismatches++;
                $display("%0t: frame with none pending: expected none, actual %h", $time, got);
                return;
            end
            want = decoded_frames.pop_front();
            compare_field("frame_ok", want.frame_ok, got.frame_ok);
            compare_field("command_one", want.command_one, got.command_one);
            compare_field("command_two", want.command_two, got.command_two);
            compare_field("right_rpm", want.right_rpm, got.right_rpm);
            compare_field("left_rpm", want.left_rpm, got.left_rpm);
            compare_field("battery_voltage", want.battery_voltage, got.battery_voltage);
            compare_field("board_temperature", want.board_temperature,
                          got.board_temperature);
            compare_field("led_flags", want.led_flags, got.led_flags);
            compare_field("frames_seen", want.frames_seen, got.frames_seen);
            compare_field("checksum_errors", want.checksum_errors, got.checksum_errors);
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_write_en;
    logic [15:0]        cfg_write_data;
    logic               in_valid;
    logic               in_stall;
    logic [7:0]         rx_byte;
    logic               out_valid;
    logic               out_stall;
    logic               frame_ok;
    logic signed [15:0] command_one;
    logic signed [15:0] command_two;
    logic signed [15:0] right_rpm;
    logic signed [15:0] left_rpm;
    logic signed [15:0] battery_voltage;
    logic signed [15:0] board_temperature;
    logic        [15:0] led_flags;
    logic        [31:0] frames_seen;
    logic        [31:0] checksum_errors;

    frame_decode_tracker tracker = new();
    logic [15:0]         plan [sffp_pkg::FRAME_WORDS];
    int unsigned         send_idle_pct = 0;
    int unsigned         stall_pct     = 0;
    int unsigned         frame_bytes_sent = 0;
    int unsigned         quiet_cycles = 0;

    serial_feedback_frame_parser_unit uut
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write_en      (cfg_write_en),
        .cfg_write_data    (cfg_write_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .rx_byte           (rx_byte),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .frame_ok          (frame_ok),
        .command_one       (command_one),
        .command_two       (command_two),
        .right_rpm         (right_rpm),
        .left_rpm          (left_rpm),
        .battery_voltage   (battery_voltage),
        .board_temperature (board_temperature),
        .led_flags         (led_flags),
        .frames_seen       (frames_seen),
        .checksum_errors   (checksum_errors)
    );

    always #1 clk = ~clk;

    // Result side: check each accepted frame and stall at random.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.match_frame(sffp_pkg::result_t'({frame_ok, command_one, command_two,
                                                     right_rpm, left_rpm, battery_voltage,
                                                     board_temperature, led_flags,
                                                     frames_seen, checksum_errors}));
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Watchdog on cycles in which no request moves on either side.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Sends one byte request, with a random gap first, and holds it until taken.
    task automatic push_rx_byte(input logic [7:0] b);
        int unsigned gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (in_stall);
        tracker.take_byte(b);
    endtask

    function automatic logic [15:0] pick_word();
        case ($urandom_range(9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h8000;
            3: return 16'h7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Fills the data words of the planned frame behind the current marker.
    function automatic void fill_random_plan();
        plan[0] = tracker.marker;
        for (int i = 1; i < sffp_pkg::FRAME_WORDS; i++)
            plan[i] = pick_word();
    endfunction

    // Sets the checksum word, corrupted when a failed frame is wanted.
    function automatic void seal_plan(input bit good);
        logic [15:0] parity;
        parity = '0;
        for (int i = 0; i < sffp_pkg::CHECKED_WORDS; i++)
            parity ^= plan[i];
        plan[sffp_pkg::FRAME_WORDS - 1] = good ? parity : parity ^ 16'($urandom_range(1, 65535));
    endfunction

    // Sends the planned frame bytes from first to last, low byte of each word first.
    task automatic send_plan(input int first, input int last);
        for (int k = first; k <= last; k++)
        begin
            push_rx_byte((k % 2) ? plan[k / 2][15:8] : plan[k / 2][7:0]);
            frame_bytes_sent++;
        end
    endtask

    // Stops sending and waits until every pending frame has been delivered.
    task automatic settle();
        in_valid <= 1'b0;
        while (tracker.decoded_frames.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_marker(input logic [15:0] value);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
        tracker.set_marker(value);
    endtask

    function automatic logic [15:0] marker_for_phase(input int unsigned p);
        case (p % 6)
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h00FF;
            3: return sffp_pkg::START_WORD_RESET;
            4: return 16'($urandom);
            default: return 16'hFF00;
        endcase
    endfunction

    initial
    begin
        int unsigned phase;
        int unsigned pick;
        int unsigned split;

        rst_n          <= 1'b0;
        cfg_write_en   <= 1'b0;
        cfg_write_data <= '0;
        in_valid       <= 1'b0;
        rx_byte        <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Idle bytes, including the marker bytes in the wrong order.
        push_rx_byte(8'h00);
        push_rx_byte(8'hFF);
        push_rx_byte(8'hAB);
        push_rx_byte(8'hCD);

        // A good frame carrying the extreme word values.
        plan = '{sffp_pkg::START_WORD_RESET, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000,
                 16'h0001, 16'hFFFE, 16'hA5A5, 16'h0000};
        seal_plan(1'b1);
        send_plan(0, sffp_pkg::FRAME_BYTES - 1);

        // A frame cut short by a new start word, then a failed checksum.
        plan = '{sffp_pkg::START_WORD_RESET, 16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0,
                 16'h0F0F, 16'hF0F0, 16'h3C3C, 16'h0000};
        seal_plan(1'b1);
        send_plan(0, 7);
        seal_plan(1'b0);
        send_plan(0, sffp_pkg::FRAME_BYTES - 1);

        // Random phases, each with its own idling pattern and start marker.
        phase = 0;
        while (frame_bytes_sent < 550)
        begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 55; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 55; end
                default: begin send_idle_pct = 26; stall_pct = 26; end
            endcase
            for (int s = 0; s < 6; s++)
            begin
                pick = $urandom_range(99);
                if (pick < 10)
                    repeat ($urandom_range(1, 6)) push_rx_byte(8'($urandom));
                else if (pick < 22)
                begin
                    fill_random_plan();
                    seal_plan(1'b1);
                    send_plan(0, $urandom_range(2, 14));
                end
                else
                begin
                    fill_random_plan();
                    seal_plan(pick >= 35);
                    send_plan(0, sffp_pkg::FRAME_BYTES - 1);
                end
            end

            // Change the marker, sometimes with a frame left half collected.
            if ($urandom_range(1))
            begin
                fill_random_plan();
                seal_plan(1'b1);
                split = $urandom_range(2, sffp_pkg::FRAME_BYTES - 1);
                send_plan(0, split - 1);
                settle();
                write_marker(marker_for_phase(phase));
                send_plan(split, sffp_pkg::FRAME_BYTES - 1);
            end
            else
            begin
                settle();
                write_marker(marker_for_phase(phase));
            end
            phase++;
        end

        settle();
        if (tracker.mismatches == 0 && tracker.decoded_frames.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: serial_feedback_frame_parser_unit.f
design/sffp_pkg.sv
design/sffp_frame_core.sv
design/serial_feedback_frame_parser_unit.sv
dv/tb_serial_feedback_frame_parser_unit.sv
